// ===== hw/rtl/msr_pkg.sv =====
package msr_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_IDX   = $clog2(WORD_BITS);
  localparam int CNT_BITS  = $clog2(WORD_BITS) + 1;
  localparam int K_LIMIT   = 4096;
  localparam int K_BITS    = $clog2(K_LIMIT);

  typedef logic [WORD_BITS-1:0] word_t;

  // one request to the shared modular multiplier
  typedef struct packed {
    logic  start;
    word_t x;
    word_t y;
    word_t p;
  } mm_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_JAC_A,
    S_SPLIT,
    S_POW_RED,
    S_POW_CHK,
    S_POW_MUL,
    S_POW_SQ,
    S_FIN3,
    S_GOT_B,
    S_JAC_K,
    S_GOT_G,
    S_GOT_RES,
    S_LOOP,
    S_SQ,
    S_GP_CHK,
    S_GP,
    S_RES_MUL,
    S_G_MUL,
    S_B_MUL,
    S_DONE
  } state_t;

  // (x + y) mod p for x, y < p, without overflow
  function automatic word_t add_mod(word_t x, word_t y, word_t p);
    word_t gap;
    gap = p - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

endpackage

// ===== hw/rtl/msr_mulmod.sv =====
module msr_mulmod import msr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output logic    done,
  output word_t   prod
);

  word_t              acc_r;
  word_t              x_r;
  word_t              y_r;
  word_t              p_r;
  logic [BIT_IDX-1:0] cnt_r;
  logic               ph_r;
  logic               busy_r;
  logic               done_r;

  // MSB-first double-and-add, at most one modular add per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        x_r    <= req.x;
        y_r    <= req.y;
        p_r    <= req.p;
        cnt_r  <= BIT_IDX'(WORD_BITS - 1);
        ph_r   <= 1'b0;
      end else if (busy_r) begin
        if (!ph_r) begin
          acc_r <= add_mod(acc_r, acc_r, p_r);
          ph_r  <= 1'b1;
        end else begin
          if (y_r[WORD_BITS-1]) begin
            acc_r <= add_mod(acc_r, x_r, p_r);
          end
          y_r  <= {y_r[WORD_BITS-2:0], 1'b0};
          ph_r <= 1'b0;
          if (cnt_r == '0) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== hw/rtl/msr_jacobi.sv =====
module msr_jacobi import msr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t a_in,
  input  word_t n_in,
  output logic  done,
  output logic  nonres
);

  word_t                a_r;
  word_t                n_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;
  logic                 nonres_r;
  logic [WORD_BITS:0]   diff;

  assign diff = {1'b0, a_r} - {1'b0, n_r};

  // binary Jacobi: strip a factor two, swap, or subtract, one per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= a_in;
        n_r    <= n_in;
        neg_r  <= 1'b0;
      end else if (busy_r) begin
        if (a_r == '0) begin
          busy_r   <= 1'b0;
          done_r   <= 1'b1;
          nonres_r <= (n_r == word_t'(1)) && neg_r;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
          if (n_r[2:0] == 3'd3 || n_r[2:0] == 3'd5) begin
            neg_r <= ~neg_r;
          end
        end else if (diff[WORD_BITS]) begin
          a_r <= n_r;
          n_r <= a_r;
          if (a_r[1:0] == 2'd3 && n_r[1:0] == 2'd3) begin
            neg_r <= ~neg_r;
          end
        end else begin
          a_r <= diff[WORD_BITS-1:0];
        end
      end
    end
  end

  assign done   = done_r;
  assign nonres = nonres_r;

endmodule

// ===== hw/rtl/modular_square_root.sv =====
// A value of 0 or 1, or an unusable modulus, goes straight to the done state.
// Otherwise each modular multiply holds the shared multiplier for 128 double/add
// steps plus issue and handoff: a 3 mod 4 prime costs about 130 multiplies, other
// primes a few hundred, plus the Jacobi unit per candidate. Throughput: one item
// at a time; in_stall stays high until the result is registered. Reset (rst_n,
// synchronous) sets the modulus to 3, empties output.
module modular_square_root import msr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_root,
  output logic        out_no_root,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data
);

  state_t              state_r, state_nxt, pret_r;
  logic [63:0]         prime_r;
  word_t               a_r, p_r, q_r, b_r, g_r, res_r, sq_r, gp_r;
  word_t               pbase_r, pe_r, pacc_r, root_r;
  logic                nr_r;
  logic [CNT_BITS-1:0] r_r, m_r, i_r, iter_r;
  logic [K_BITS-1:0]   k_r;
  logic                issued_r;
  logic                out_valid_r, out_no_root_r;
  logic [63:0]         out_root_r;

  mm_req_t mm_req;
  logic    mm_done, jac_start, jac_done, jac_nonres, accept, is_mul, is_jac;
  word_t   prod, jac_a, in_word;
  logic    sq_more, gp_more, p_bad;

  assign in_word = in_value[WORD_BITS-1:0];
  assign accept  = in_valid && !in_stall;
  assign p_bad   = (prime_r[WORD_BITS-1:0] < word_t'(3)) || !prime_r[0];
  assign sq_more = ((CNT_BITS+1)'(m_r) + (CNT_BITS+1)'(1) < (CNT_BITS+1)'(r_r))
                   && (prod != word_t'(1));
  assign gp_more = (CNT_BITS+1)'(i_r) + (CNT_BITS+1)'(m_r) < (CNT_BITS+1)'(r_r);

  msr_mulmod u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mm_req),
    .done (mm_done),
    .prod (prod)
  );

  msr_jacobi u_jac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (jac_start),
    .a_in  (jac_a),
    .n_in  (p_r),
    .done  (jac_done),
    .nonres(jac_nonres)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word <= word_t'(1) || p_bad) state_nxt = S_DONE;
          else                                  state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) state_nxt = (prod == '0) ? S_DONE : S_JAC_A;
      end
      S_JAC_A: begin
        if (jac_done) begin
          if (jac_nonres)             state_nxt = S_DONE;
          else if (p_r[1:0] == 2'd3)  state_nxt = S_POW_RED;
          else                        state_nxt = S_SPLIT;
        end
      end
      S_SPLIT:   if (q_r[0]) state_nxt = S_POW_RED;
      S_POW_RED: if (mm_done) state_nxt = S_POW_CHK;
      S_POW_CHK: begin
        if (pe_r == '0)  state_nxt = pret_r;
        else if (pe_r[0]) state_nxt = S_POW_MUL;
        else              state_nxt = S_POW_SQ;
      end
      S_POW_MUL: if (mm_done) state_nxt = S_POW_SQ;
      S_POW_SQ:  if (mm_done) state_nxt = S_POW_CHK;
      S_FIN3:    state_nxt = S_DONE;
      S_GOT_B:   state_nxt = S_JAC_K;
      S_JAC_K: begin
        if (jac_done) begin
          if (jac_nonres)                             state_nxt = S_POW_RED;
          else if (k_r == K_BITS'(K_LIMIT - 1))       state_nxt = S_DONE;
        end
      end
      S_GOT_G:   state_nxt = S_POW_RED;
      S_GOT_RES: state_nxt = S_LOOP;
      S_LOOP: begin
        if (iter_r < CNT_BITS'(WORD_BITS) && b_r != word_t'(1)) state_nxt = S_SQ;
        else                                                     state_nxt = S_DONE;
      end
      S_SQ:      if (mm_done && !sq_more) state_nxt = S_GP_CHK;
      S_GP_CHK:  state_nxt = gp_more ? S_GP : S_RES_MUL;
      S_GP:      if (mm_done) state_nxt = S_GP_CHK;
      S_RES_MUL: if (mm_done) state_nxt = S_G_MUL;
      S_G_MUL:   if (mm_done) state_nxt = S_B_MUL;
      S_B_MUL:   if (mm_done) state_nxt = S_LOOP;
      S_DONE:    if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    is_mul   = state_r inside {S_RED, S_POW_RED, S_POW_MUL, S_POW_SQ, S_SQ, S_GP,
                               S_RES_MUL, S_G_MUL, S_B_MUL};
    is_jac   = state_r inside {S_JAC_A, S_JAC_K};
    in_stall = (state_r != S_IDLE);
    mm_req.start = is_mul && !issued_r;
    mm_req.p     = p_r;
    jac_start    = is_jac && !issued_r;
    jac_a        = (state_r == S_JAC_A) ? a_r : word_t'(k_r);
    case (state_r)
      S_RED:     begin mm_req.x = word_t'(1); mm_req.y = a_r;     end
      S_POW_RED: begin mm_req.x = word_t'(1); mm_req.y = pbase_r; end
      S_POW_MUL: begin mm_req.x = pacc_r;     mm_req.y = pbase_r; end
      S_POW_SQ:  begin mm_req.x = pbase_r;    mm_req.y = pbase_r; end
      S_SQ:      begin mm_req.x = sq_r;       mm_req.y = sq_r;    end
      S_RES_MUL: begin mm_req.x = res_r;      mm_req.y = gp_r;    end
      S_B_MUL:   begin mm_req.x = b_r;        mm_req.y = g_r;     end
      default:   begin mm_req.x = gp_r;       mm_req.y = gp_r;    end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prime_r     <= 64'd3;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) prime_r <= cfg_data;
      if (mm_req.start || jac_start)   issued_r <= 1'b1;
      else if (mm_done || jac_done)    issued_r <= 1'b0;
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r   <= 1'b1;
        out_root_r    <= 64'(root_r);
        out_no_root_r <= nr_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        a_r    <= in_word;
        p_r    <= prime_r[WORD_BITS-1:0];
        root_r <= (in_word <= word_t'(1)) ? in_word : '0;
        nr_r   <= 1'b0;
      end
      S_RED: if (mm_done) a_r <= prod;
      S_JAC_A: begin
        if (jac_done) begin
          nr_r    <= jac_nonres;
          q_r     <= p_r - word_t'(1);
          r_r     <= '0;
          pbase_r <= a_r;
          pe_r    <= (p_r >> 2) + word_t'(1);
          pacc_r  <= word_t'(1);
          pret_r  <= S_FIN3;
        end
      end
      S_SPLIT: begin
        if (!q_r[0]) begin
          q_r <= q_r >> 1;
          r_r <= r_r + 1'b1;
        end else begin
          pbase_r <= a_r;
          pe_r    <= q_r;
          pacc_r  <= word_t'(1);
          pret_r  <= S_GOT_B;
        end
      end
      S_POW_RED: if (mm_done) pbase_r <= prod;
      S_POW_MUL: if (mm_done) pacc_r <= prod;
      S_POW_SQ: begin
        if (mm_done) begin
          pbase_r <= prod;
          pe_r    <= pe_r >> 1;
        end
      end
      S_FIN3: root_r <= pacc_r;
      S_GOT_B: begin
        b_r <= pacc_r;
        k_r <= K_BITS'(2);
      end
      S_JAC_K: begin
        if (jac_done) begin
          k_r     <= k_r + 1'b1;
          pbase_r <= word_t'(k_r);
          pe_r    <= q_r;
          pacc_r  <= word_t'(1);
          pret_r  <= S_GOT_G;
        end
      end
      S_GOT_G: begin
        g_r     <= pacc_r;
        pbase_r <= a_r;
        pe_r    <= (q_r >> 1) + word_t'(1);
        pacc_r  <= word_t'(1);
        pret_r  <= S_GOT_RES;
      end
      S_GOT_RES: begin
        res_r  <= pacc_r;
        iter_r <= '0;
      end
      S_LOOP: begin
        sq_r   <= b_r;
        gp_r   <= g_r;
        m_r    <= '0;
        root_r <= res_r;
      end
      S_SQ: begin
        if (mm_done) begin
          sq_r <= prod;
          m_r  <= m_r + 1'b1;
          i_r  <= CNT_BITS'(1);
        end
      end
      S_GP: begin
        if (mm_done) begin
          gp_r <= prod;
          i_r  <= i_r + 1'b1;
        end
      end
      S_RES_MUL: if (mm_done) res_r <= prod;
      S_G_MUL:   if (mm_done) g_r <= prod;
      S_B_MUL: begin
        if (mm_done) begin
          b_r    <= prod;
          r_r    <= m_r;
          iter_r <= iter_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_root    = out_root_r;
  assign out_no_root = out_no_root_r;

endmodule

// ===== hw/rtl/msr_chk.sv =====
module msr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_root,
  input logic        out_no_root
);

  // a non-residue always reports root zero
  a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_root |-> out_root == 64'd0)
    else $error("no_root item with nonzero root");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  a_rst: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root) && $stable(out_no_root))
    else $error("stalled output item changed");

endmodule

bind modular_square_root msr_chk u_msr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_root   (out_root),
  .out_no_root(out_no_root)
);

// ===== test/tb_top.sv =====
module tb_top;
  import msr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct {
    word_t root;
    logic  no_root;
  } root_exp_t;

  // one directed row: optional modulus write, then one item
  typedef struct packed {
    logic  set_mod;
    word_t modv;
    word_t val;
    logic  known;
    word_t root;
    logic  no_root;
  } dir_row_t;

  typedef struct packed {
    word_t modv;
    int    count;
  } mod_phase_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_root;
  logic        out_no_root;
  logic        cfg_we;
  logic [63:0] cfg_data;

  root_exp_t   root_q[$];
  word_t       cur_mod;
  idle_mode_t  idle_mode;
  bit          failed;
  int          quiet_cycles;

  modular_square_root uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_root   (out_root),
    .out_no_root(out_no_root),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic word_t mulm(word_t x, word_t y, word_t p);
    logic [127:0] prod;
    prod = x * y;
    return word_t'(prod % p);
  endfunction

  function automatic word_t powm(word_t base, word_t e, word_t p);
    word_t acc;
    word_t b;
    acc = 1 % p;
    b = base % p;
    while (e != 0) begin
      if (e[0]) acc = mulm(acc, b, p);
      b = mulm(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic int jacobi_sym(word_t a, word_t n);
    int    t;
    word_t tmp;
    t = 1;
    a = a % n;
    while (a != 0) begin
      while (!a[0]) begin
        a = a >> 1;
        if (n[2:0] == 3 || n[2:0] == 5) t = -t;
      end
      tmp = a;
      a = n;
      n = tmp;
      if (a[1:0] == 2'b11 && n[1:0] == 2'b11) t = -t;
      a = a % n;
    end
    return (n == 1) ? t : 0;
  endfunction

  function automatic root_exp_t predict_root(word_t v, word_t p);
    root_exp_t e;
    word_t     a, q, b, g, res, k, sq, gp;
    int        r, m, iter;
    bit        found;
    e.root = '0;
    e.no_root = 1'b0;
    a = v;
    if (a <= 1) begin
      e.root = a;
      return e;
    end
    if (p < 3 || !p[0]) return e;
    a = a % p;
    if (a == 0) return e;
    if (jacobi_sym(a, p) == -1) begin
      e.no_root = 1'b1;
      return e;
    end
    if (p[1:0] == 2'b11) begin
      e.root = powm(a, (p >> 2) + 1, p);
      return e;
    end
    q = p - 1;
    r = 0;
    while (!q[0]) begin
      q = q >> 1;
      r++;
    end
    b = powm(a, q, p);
    found = 0;
    for (k = 2; k < K_LIMIT; k++) begin
      if (jacobi_sym(k, p) == -1) begin
        found = 1;
        break;
      end
    end
    if (!found) return e;
    g = powm(k, q, p);
    res = powm(a, (q >> 1) + 1, p);
    for (iter = 0; iter < WORD_BITS && b != 1; iter++) begin
      sq = b;
      gp = g;
      m = 0;
      do begin
        sq = mulm(sq, sq, p);
        m++;
      end while (m < r && sq != 1);
      for (int i = 1; i + m < r; i++) gp = mulm(gp, gp, p);
      res = mulm(res, gp, p);
      g = mulm(gp, gp, p);
      b = mulm(b, g, p);
      r = m;
    end
    e.root = res;
    return e;
  endfunction

  // wait for all results, then let the block settle before a modulus write
  task automatic write_modulus(word_t m);
    while (root_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_mod = m;
  endtask

  task automatic send_item(word_t v, logic known, word_t r, logic nr);
    root_exp_t e;
    while ((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
           $urandom_range(0, 99) < ((idle_mode == IDLE_SEND) ? 71 : 35)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (known) begin
      e.root = r;
      e.no_root = nr;
    end else begin
      e = predict_root(v, cur_mod);
    end
    root_q.push_back(e);
  endtask

  function automatic word_t pick_value(word_t p);
    word_t x;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        x = {$urandom, $urandom} % p;
        return mulm(x, x, p);
      end
      5, 6: return {$urandom, $urandom};
      7: return {$urandom, $urandom} % p;
      8: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return word_t'(1);
          default: return p * $urandom_range(1, 1000);
        endcase
      end
      default: return '1 - $urandom_range(0, 3);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (idle_mode == IDLE_RECV) out_stall <= ($urandom_range(0, 99) < 71);
    else if (idle_mode == IDLE_BOTH) out_stall <= ($urandom_range(0, 99) < 35);
    else out_stall <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    root_exp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (root_q.size() == 0) begin
        $error("unexpected item: root %h no_root %b", out_root, out_no_root);
        failed = 1'b1;
      end else begin
        e = root_q.pop_front();
        if (out_root !== e.root) begin
          $error("root: expected %h, got %h", e.root, out_root);
          failed = 1'b1;
        end
        if (out_no_root !== e.no_root) begin
          $error("no_root: expected %b, got %b", e.no_root, out_no_root);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  dir_row_t dir_tab[] = '{
    '{1'b0, 64'd3, 64'd0, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'd3, 64'd1, 1'b1, 64'd1, 1'b0},
    '{1'b0, 64'd3, 64'd2, 1'b1, 64'd0, 1'b1},
    '{1'b0, 64'd3, 64'd3, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'd3, 64'd4, 1'b1, 64'd1, 1'b0},
    '{1'b0, 64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd0, 1'b0},
    '{1'b1, 64'd4, 64'd5, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'd4, 64'd1, 1'b1, 64'd1, 1'b0},
    '{1'b1, 64'd2, 64'd2, 1'b1, 64'd0, 1'b0},
    '{1'b1, 64'd1, 64'd7, 1'b1, 64'd0, 1'b0},
    '{1'b1, 64'd13, 64'd10, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'd13, 64'd5, 1'b1, 64'd0, 1'b1},
    '{1'b0, 64'd13, 64'd26, 1'b1, 64'd0, 1'b0},
    '{1'b1, 64'd9, 64'd7, 1'b1, 64'd0, 1'b0},
    '{1'b0, 64'd9, 64'd9, 1'b1, 64'd0, 1'b0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFC5, 64'h8000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFC5, 64'd4, 1'b0, 64'd0, 1'b0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0, 1'b0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd4, 1'b0, 64'd0, 1'b0}
  };

  // mostly small primes keep the multiply count low; a few large moduli
  mod_phase_t mod_plan[] = '{
    '{64'd5, 100}, '{64'd7, 100}, '{64'd13, 100}, '{64'd17, 100},
    '{64'd41, 100}, '{64'd97, 100}, '{64'd193, 100}, '{64'd257, 100},
    '{64'd641, 100}, '{64'd7681, 100}, '{64'd12289, 100}, '{64'd65537, 100},
    '{64'd3, 60}, '{64'd2147483647, 40}, '{64'd998244353, 15},
    '{64'hFFFF_FFFF_FFFF_FFC5, 8}, '{64'd15, 30}, '{64'd21, 30},
    '{64'hFFFF_FFFF_FFFF_FFFF, 8}, '{64'd4, 15}, '{64'd1, 15}, '{64'd9, 2}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    failed = 1'b0;
    cur_mod = 64'd3;
    idle_mode = IDLE_NONE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_mod) begin
        in_valid <= 1'b0;
        write_modulus(dir_tab[i].modv);
      end
      send_item(dir_tab[i].val, dir_tab[i].known, dir_tab[i].root, dir_tab[i].no_root);
    end

    foreach (mod_plan[ph]) begin
      in_valid <= 1'b0;
      write_modulus(mod_plan[ph].modv);
      idle_mode = idle_mode_t'(ph % 4);
      for (int n = 0; n < mod_plan[ph].count; n++)
        send_item(pick_value(cur_mod), 1'b0, '0, 1'b0);
    end
    in_valid <= 1'b0;

    while (root_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
